/* rtl/bthalloc_pkg.sv */
// ----------------------------------------------------------------------------
// Boundary-tag allocator package
// Word types for the request and result channels and the fixed tag layout.
// ----------------------------------------------------------------------------
package bthalloc_pkg;

  localparam int TAG_W     = 16;  // width of one heap word
  localparam int SIZE_W    = 15;  // size field of a tag
  localparam int FREE_BIT  = 15;  // tag bit that marks a free block
  localparam int REQ_W     = 12;
  localparam int ADDR_W    = 12;
  localparam int NEED_W    = REQ_W + 1;
  localparam int MIN_BLOCK = 4;
  localparam int TAG_WORDS = 2;
  localparam logic [7:0] THRESH_RESET = 8'd26;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_words;
    logic [ADDR_W-1:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [1:0]        status;
  } out_word_t;

endpackage

/* rtl/bthalloc_ram.sv */
// ----------------------------------------------------------------------------
// Heap word memory
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bthalloc_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/boundary_tag_heap_allocator.sv */
// ----------------------------------------------------------------------------
// Boundary-tag first-fit heap allocator
// An allocate walks the free list from the head, reading each block's tag,
//   then splits the first block that fits or unlinks and hands out the whole
//   one; a free checks the block's tags and both neighbors, then merges or links.
// Requests are taken one at a time; the heap RAM, never read and written in
//   the same cycle, is shared by the walk and by the tag and link updates.
// Reset (synchronous) starts a clearing pass that writes the initial heap
//   image; requests are stalled until it completes.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bthalloc_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bthalloc_pkg::out_word_t out_word,
  input  logic                   cfg_write,
  input  logic [7:0]             cfg_data
);

  import bthalloc_pkg::*;

  localparam int AW  = $clog2(HEAP_WORDS);
  // Address arithmetic is wide enough for any link value plus two sizes.
  localparam int XW  = ((AW > TAG_W) ? AW : TAG_W) + 2;
  localparam int SZW = SIZE_W + 2;
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_WORDS);

  typedef enum logic [14:0] {
    IDLE   = 15'b000000000000001,
    CLEAR  = 15'b000000000000010,
    A_CHK  = 15'b000000000000100,
    A_TAG  = 15'b000000000001000,
    A_NEXT = 15'b000000000010000,
    F_ISS  = 15'b000000000100000,
    F_T    = 15'b000000001000000,
    F_TT   = 15'b000000010000000,
    F_L    = 15'b000000100000000,
    F_R    = 15'b000001000000000,
    RD_N   = 15'b000010000000000,
    RD_V   = 15'b000100000000000,
    RD_C   = 15'b001000000000000,
    WR     = 15'b010000000000000,
    DONE   = 15'b100000000000000
  } state_t;

  // Update program chosen once the block and its neighbors are known.
  typedef enum logic [2:0] {
    K_WHOLE, K_SPLIT, K_LEFT, K_RIGHT, K_BOTH, K_NONE
  } kind_t;

  state_t state;
  kind_t  kind;

  logic [AW-1:0]     clr;
  logic [7:0]        thr;
  logic [TAG_W-1:0]  head;
  logic [XW-1:0]     p, u, l, ba, q;
  logic [TAG_W-1:0]  t, n, v;
  logic [SIZE_W-1:0] s, ls;
  logic [NEED_W-1:0] need;
  logic [SZW-1:0]    sz;
  logic              tfree, lf;
  logic [2:0]        step;
  logic [AW:0]       steps;
  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;
  logic              rd_zero;

  // RAM port signals.
  logic              mem_we, mem_re;
  logic [XW-1:0]     w_addr, r_addr;
  logic [TAG_W-1:0]  w_data, mem_rdata, rdata;
  logic [AW-1:0]     mem_waddr;
  logic [TAG_W-1:0]  mem_wdata;

  // Write program outputs.
  logic              w_en, head_we, last;
  logic [TAG_W-1:0]  head_d;

  // Decisions on the word just read.
  logic [SIZE_W-1:0] tag_s, k;
  logic              fits, whole, bad, lf_c, rf_c;
  logic [NEED_W-1:0] need_c;
  logic [TAG_W-1:0]  tagv;
  logic [XW-1:0]     ea;

  function automatic logic [TAG_W-1:0] init_word(input logic [AW-1:0] idx);
    logic [TAG_W-1:0] w;
    w = '0;
    if (idx == '0 || idx == AW'(HEAP_WORDS - 1)) begin
      w = TAG_W'(1);
    end else if (idx == AW'(1) || idx == AW'(HEAP_WORDS - 2)) begin
      w = {1'b1, SIZE_W'(HEAP_WORDS - 2)};
    end
    return w;
  endfunction

  bthalloc_ram #(
    .DEPTH (HEAP_WORDS),
    .DW    (TAG_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (r_addr[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Reads beyond the heap return zero.
  assign rdata = rd_zero ? '0 : mem_rdata;

  // The clearing pass writes the reset image at the counter address.
  assign mem_waddr = (state == CLEAR) ? clr : w_addr[AW-1:0];
  assign mem_wdata = (state == CLEAR) ? init_word(clr) : w_data;

  assign in_stall = (state != IDLE);

  assign tag_s  = rdata[SIZE_W-1:0];
  assign need_c = (NEED_W'(in_word.request_words) + NEED_W'(TAG_WORDS) < NEED_W'(MIN_BLOCK))
                ? NEED_W'(MIN_BLOCK)
                : NEED_W'(in_word.request_words) + NEED_W'(TAG_WORDS);
  assign fits   = tag_s >= SIZE_W'(need);
  assign k      = tag_s - SIZE_W'(need);
  assign whole  = (k <= SIZE_W'(thr)) || (k < SIZE_W'(MIN_BLOCK));
  assign bad    = rdata[FREE_BIT] || (tag_s < SIZE_W'(MIN_BLOCK))
                || (p + XW'(tag_s) > HEAP_X - XW'(1));
  assign lf_c   = rdata[FREE_BIT] && (tag_s >= SIZE_W'(MIN_BLOCK)) && (XW'(tag_s) <= p);
  assign rf_c   = rdata[FREE_BIT] && (tag_s >= SIZE_W'(MIN_BLOCK))
                && (p + XW'(s) + XW'(tag_s) <= HEAP_X);

  assign tagv = {tfree, sz[SIZE_W-1:0]};
  assign ea   = ba + XW'(sz) - XW'(1);

  // Read address for each state that looks at the heap.
  always_comb begin
    mem_re = 1'b1;
    r_addr = p;
    case (state)
      A_CHK:   r_addr = p;
      A_TAG:   r_addr = p + XW'(1);
      F_ISS:   r_addr = p;
      F_T:     r_addr = p + XW'(tag_s) - XW'(1);
      F_TT:    r_addr = p - XW'(1);
      F_L:     r_addr = p + XW'(s);
      RD_N:    r_addr = u + XW'(1);
      RD_V:    r_addr = u + XW'(2);
      default: mem_re = 1'b0;
    endcase
  end

  // The write program: at most one heap word per step, plus the list head where
  // it changes, in the same order as the tag and link updates of the boundary-tag algorithm.
  always_comb begin
    w_en    = 1'b0;
    w_addr  = ba;
    w_data  = tagv;
    head_we = 1'b0;
    head_d  = n;
    last    = 1'b0;
    case (kind)
      K_WHOLE, K_BOTH: begin
        case (step)
          3'd0: begin
            if (v == '0) begin
              head_we = 1'b1;
            end else begin
              w_en   = 1'b1;
              w_addr = XW'(v) + XW'(1);
              w_data = n;
            end
          end
          3'd1: begin
            w_en   = (n != '0);
            w_addr = XW'(n) + XW'(2);
            w_data = v;
          end
          3'd2: w_en = 1'b1;
          default: begin
            w_en   = 1'b1;
            w_addr = ea;
            last   = 1'b1;
          end
        endcase
      end
      K_SPLIT: begin
        case (step)
          3'd0: w_en = 1'b1;
          3'd1: begin
            w_en   = 1'b1;
            w_addr = ea;
          end
          3'd2: begin
            w_en   = 1'b1;
            w_addr = q;
            w_data = TAG_W'(need);
          end
          default: begin
            w_en   = 1'b1;
            w_addr = q + XW'(need) - XW'(1);
            w_data = TAG_W'(need);
            last   = 1'b1;
          end
        endcase
      end
      K_LEFT: begin
        w_en = 1'b1;
        if (step != 3'd0) begin
          w_addr = ea;
          last   = 1'b1;
        end
      end
      K_RIGHT: begin
        case (step)
          3'd0: w_en = 1'b1;
          3'd1: begin
            w_en   = 1'b1;
            w_addr = ea;
          end
          3'd2: begin
            w_en   = 1'b1;
            w_addr = p + XW'(1);
            w_data = n;
          end
          3'd3: begin
            w_en   = 1'b1;
            w_addr = p + XW'(2);
            w_data = v;
          end
          3'd4: begin
            head_d = p[TAG_W-1:0];
            if (v == '0) begin
              head_we = 1'b1;
            end else begin
              w_en   = 1'b1;
              w_addr = XW'(v) + XW'(1);
              w_data = p[TAG_W-1:0];
            end
          end
          default: begin
            w_en   = (n != '0);
            w_addr = XW'(n) + XW'(2);
            w_data = p[TAG_W-1:0];
            last   = 1'b1;
          end
        endcase
      end
      default: begin
        // Neither neighbor is free: push the block at the head of the list.
        case (step)
          3'd0: w_en = 1'b1;
          3'd1: begin
            w_en   = 1'b1;
            w_addr = ea;
          end
          3'd2: begin
            w_en   = 1'b1;
            w_addr = p + XW'(1);
            w_data = n;
          end
          3'd3: begin
            w_en   = 1'b1;
            w_addr = p + XW'(2);
            w_data = '0;
          end
          default: begin
            w_en    = (n != '0);
            w_addr  = XW'(n) + XW'(2);
            w_data  = p[TAG_W-1:0];
            head_we = 1'b1;
            head_d  = p[TAG_W-1:0];
            last    = 1'b1;
          end
        endcase
      end
    endcase
  end

  // Writes during the clearing pass come from the counter; others from the
  // program, dropped when they fall outside the heap.
  always_comb begin
    mem_we = 1'b0;
    if (state == CLEAR) begin
      mem_we = 1'b1;
    end else if (state == WR) begin
      mem_we = w_en && (w_addr < HEAP_X);
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= !(r_addr < HEAP_X);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr       <= '0;
      thr       <= THRESH_RESET;
      head      <= TAG_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        thr <= cfg_data;
      end
      // In DONE the result register is refilled below instead.
      if (out_valid && !out_stall && state != DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(HEAP_WORDS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            if (in_word.operation == OP_ALLOC) begin
              need  <= need_c;
              p     <= XW'(head);
              steps <= '0;
              state <= A_CHK;
            end else begin
              res_addr   <= '0;
              res_status <= ST_FREED;
              p          <= XW'(in_word.block_address) - XW'(1);
              state      <= (in_word.block_address < ADDR_W'(2)) ? DONE : F_ISS;
            end
          end
        end
        A_CHK: begin
          if (p != '0 && steps < (AW + 1)'(HEAP_WORDS)) begin
            state <= A_TAG;
          end else begin
            res_addr   <= '0;
            res_status <= ST_NO_FIT;
            state      <= DONE;
          end
        end
        A_TAG: begin
          if (fits) begin
            res_status <= ST_ALLOCATED;
            ba         <= p;
            step       <= '0;
            if (whole) begin
              kind     <= K_WHOLE;
              sz       <= SZW'(tag_s);
              tfree    <= 1'b0;
              u        <= p;
              res_addr <= ADDR_W'(p + XW'(1));
              state    <= RD_N;
            end else begin
              kind     <= K_SPLIT;
              sz       <= SZW'(k);
              tfree    <= 1'b1;
              q        <= p + XW'(k);
              res_addr <= ADDR_W'(p + XW'(k) + XW'(1));
              state    <= WR;
            end
          end else begin
            state <= A_NEXT;
          end
        end
        A_NEXT: begin
          p     <= XW'(rdata);
          steps <= steps + (AW + 1)'(1);
          state <= A_CHK;
        end
        F_ISS: state <= F_T;
        F_T: begin
          t     <= rdata;
          s     <= tag_s;
          state <= bad ? DONE : F_TT;
        end
        F_TT: state <= (rdata != t) ? DONE : F_L;
        F_L: begin
          lf    <= lf_c;
          ls    <= tag_s;
          l     <= p - XW'(tag_s);
          state <= F_R;
        end
        F_R: begin
          tfree <= 1'b1;
          step  <= '0;
          u     <= p + XW'(s);
          if (lf && !rf_c) begin
            kind  <= K_LEFT;
            ba    <= l;
            sz    <= SZW'(ls) + SZW'(s);
            state <= WR;
          end else if (!lf && rf_c) begin
            kind  <= K_RIGHT;
            ba    <= p;
            sz    <= SZW'(s) + SZW'(tag_s);
            state <= RD_N;
          end else if (lf && rf_c) begin
            kind  <= K_BOTH;
            ba    <= l;
            sz    <= SZW'(ls) + SZW'(s) + SZW'(tag_s);
            state <= RD_N;
          end else begin
            kind  <= K_NONE;
            ba    <= p;
            sz    <= SZW'(s);
            n     <= head;
            state <= WR;
          end
        end
        RD_N: state <= RD_V;
        RD_V: begin
          n     <= rdata;
          state <= RD_C;
        end
        RD_C: begin
          v     <= rdata;
          step  <= '0;
          state <= WR;
        end
        WR: begin
          if (head_we) begin
            head <= head_d;
          end
          step <= step + 3'd1;
          if (last) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            out_word.address <= res_addr;
            out_word.status  <= res_status;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // The RAM port is never asked to read and write in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("heap RAM read and write overlap");

  // An accepted request always holds off the next one: the stall is raised in the following cycle.
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  // A free never reports an address.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status == ST_FREED) |-> (out_word.address == '0))
    else $error("free result with nonzero address");

  // Results only carry the three defined status codes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.status == ST_ALLOCATED || out_word.status == ST_NO_FIT
                   || out_word.status == ST_FREED))
    else $error("undefined result status");

endmodule

/* bench/boundary_tag_heap_allocator_test.sv */
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator testbench
// Sends allocate and free words to the allocator and checks every result
// against a first-fit heap predictor kept in the bench. The directed rows come
// first, then random traffic under several split thresholds. Both sides of the
// handshake idle and stall at random.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_test;
  import bthalloc_pkg::*;

  localparam int HEAP_WORDS = 4096;
  localparam int IDLE_LIMIT = 40000;  // covers the clearing pass and a full list walk
  localparam int PHASE_ITEMS = 250;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_write = 1'b0;
  logic [7:0] cfg_data = '0;

  always #10 clk = ~clk;

  boundary_tag_heap_allocator #(.HEAP_WORDS(HEAP_WORDS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // Shadow heap. Tags hold the free flag in the top bit and the size below it;
  // free blocks hold their next link at word 1 and previous link at word 2.
  logic [15:0]  shadow_heap [HEAP_WORDS];
  int unsigned  shadow_head;
  logic [7:0]   shadow_split;

  out_word_t    awaited_results [$];
  logic [11:0]  live_blocks [$];    // payload addresses currently allocated
  logic [11:0]  freed_blocks [$];   // recently released, for double frees
  int           failures = 0;
  int           words_sent = 0;
  int           results_seen = 0;
  int           grants = 0;
  int           refusals = 0;
  int           long_hold = 0;

  function automatic int unsigned heap_rd(int unsigned a);
    return (a < HEAP_WORDS) ? shadow_heap[a] : 0;
  endfunction

  function automatic void heap_wr(int unsigned a, int unsigned v);
    if (a < HEAP_WORDS) shadow_heap[a] = v[15:0];
  endfunction

  function automatic void write_tags(int unsigned p, int unsigned s, bit is_free);
    int unsigned t;
    t = (s & 16'h7FFF) | (is_free ? 16'h8000 : 0);
    heap_wr(p, t);
    if (s != 0) heap_wr(p + s - 1, t);
  endfunction

  function automatic void unlink_free(int unsigned p);
    int unsigned n, v;
    n = heap_rd(p + 1);
    v = heap_rd(p + 2);
    if (v == 0) shadow_head = n;
    else heap_wr(v + 1, n);
    if (n != 0) heap_wr(n + 2, v);
  endfunction

  function automatic void heap_clear();
    for (int i = 0; i < HEAP_WORDS; i++) shadow_heap[i] = '0;
    shadow_heap[0] = 16'd1;
    shadow_heap[HEAP_WORDS-1] = 16'd1;
    write_tags(1, HEAP_WORDS - 2, 1'b1);
    shadow_head = 1;
    shadow_split = THRESH_RESET;
  endfunction

  // First fit: take the whole block when the leftover is small, otherwise
  // cut the request off the top and leave the bottom on the list.
  function automatic out_word_t first_fit(int unsigned req);
    out_word_t   res;
    int unsigned need, p, steps, s, k, q;
    need = req + TAG_WORDS;
    if (need < MIN_BLOCK) need = MIN_BLOCK;
    p = shadow_head;
    steps = 0;
    res.address = '0;
    res.status = ST_NO_FIT;
    while (p != 0 && steps < HEAP_WORDS) begin
      s = heap_rd(p) & 16'h7FFF;
      if (s >= need) begin
        k = s - need;
        if (k <= shadow_split || k < MIN_BLOCK) begin
          unlink_free(p);
          write_tags(p, s, 1'b0);
          q = p;
        end else begin
          write_tags(p, k, 1'b1);
          q = p + k;
          write_tags(q, need, 1'b0);
        end
        res.address = 12'(q + 1);
        res.status = ST_ALLOCATED;
        return res;
      end
      p = heap_rd(p + 1);
      steps++;
    end
    return res;
  endfunction

  // Release with coalescing in the four neighbor cases. A request that does
  // not point at an allocated block leaves the heap alone.
  function automatic void release_block(int unsigned b);
    int unsigned p, t, s, lt, rt, ls, rs, l, r, n, v;
    bit lf, rf;
    lf = 0; rf = 0; l = 0; r = 0; ls = 0; rs = 0;
    if (b < 2) return;
    p = b - 1;
    t = heap_rd(p);
    s = t & 16'h7FFF;
    if (t[15] || s < MIN_BLOCK || p + s > HEAP_WORDS - 1 || heap_rd(p + s - 1) != t)
      return;
    lt = heap_rd(p - 1);
    if (lt[15]) begin
      ls = lt & 16'h7FFF;
      if (ls >= MIN_BLOCK && ls <= p) begin
        lf = 1; l = p - ls;
      end
    end
    rt = heap_rd(p + s);
    if (rt[15]) begin
      rs = rt & 16'h7FFF;
      if (rs >= MIN_BLOCK && p + s + rs <= HEAP_WORDS) begin
        rf = 1; r = p + s;
      end
    end
    if (lf && !rf) begin
      write_tags(l, ls + s, 1'b1);
    end else if (!lf && rf) begin
      // The merged block takes over the right neighbor's place in the list.
      n = heap_rd(r + 1);
      v = heap_rd(r + 2);
      write_tags(p, s + rs, 1'b1);
      heap_wr(p + 1, n);
      heap_wr(p + 2, v);
      if (v == 0) shadow_head = p;
      else heap_wr(v + 1, p);
      if (n != 0) heap_wr(n + 2, p);
    end else if (lf && rf) begin
      unlink_free(r);
      write_tags(l, ls + s + rs, 1'b1);
    end else begin
      n = shadow_head;
      write_tags(p, s, 1'b1);
      heap_wr(p + 1, n);
      heap_wr(p + 2, 0);
      if (n != 0) heap_wr(n + 2, p);
      shadow_head = p;
    end
  endfunction

  // Accepted words are predicted in order; accepted results are checked
  // against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && in_valid && !in_stall) begin
      words_sent++;
      if (in_word.operation == OP_ALLOC) begin
        want = first_fit(in_word.request_words);
        if (want.status == ST_ALLOCATED) begin
          live_blocks.push_back(want.address);
          grants++;
        end else begin
          refusals++;
        end
      end else begin
        release_block(in_word.block_address);
        want.address = '0;
        want.status = ST_FREED;
      end
      awaited_results.push_back(want);
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result address %0d status %0d", $time,
                 out_word.address, out_word.status);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (want.address !== out_word.address) begin
          $display("%0t: address expected %0d actual %0d", $time,
                   want.address, out_word.address);
          failures++;
        end
        if (want.status !== out_word.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_word.status);
          failures++;
        end
      end
    end
  end

  // Receiver: a long hold-off when asked, otherwise a stall pattern whose
  // density changes at random moments, including stretches with no stall.
  initial begin
    int density;
    density = 0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else begin
        if ($urandom_range(0, 63) == 0) density = $urandom_range(0, 2) * 30;
        out_stall <= ($urandom_range(0, 99) < density);
      end
    end
  end

  // Watchdog on cycles without any accepted word on either channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  typedef struct {
    logic        op;
    int unsigned req;
    int unsigned addr;
    bit          known;
    int unsigned want_addr;
    logic [1:0]  want_status;
  } directed_row_t;

  // Known results follow from the reset heap at the default threshold.
  directed_row_t directed_rows [] = '{
    '{OP_ALLOC, 1,    0,    1, 4092, ST_ALLOCATED},
    '{OP_ALLOC, 4092, 0,    1, 0,    ST_NO_FIT},     // larger than any free block
    '{OP_ALLOC, 0,    0,    1, 4088, ST_ALLOCATED},  // zero is served as one
    '{OP_FREE,  0,    0,    1, 0,    ST_FREED},      // below the first block
    '{OP_FREE,  0,    1,    1, 0,    ST_FREED},
    '{OP_FREE,  0,    4095, 1, 0,    ST_FREED},      // block would run past the top guard
    '{OP_FREE,  0,    4092, 1, 0,    ST_FREED},      // neither neighbor free
    '{OP_FREE,  0,    4092, 1, 0,    ST_FREED},      // double free is ignored
    '{OP_ALLOC, 4095, 0,    1, 0,    ST_NO_FIT},     // every request bit set
    '{OP_ALLOC, 4060, 0,    1, 2,    ST_ALLOCATED},  // small leftover given away
    '{OP_FREE,  0,    4088, 0, 0,    ST_FREED},      // right neighbor free
    '{OP_FREE,  0,    2,    0, 0,    ST_FREED},
    '{OP_ALLOC, 10,   0,    0, 0,    ST_ALLOCATED},
    '{OP_ALLOC, 10,   0,    0, 0,    ST_ALLOCATED},
    '{OP_ALLOC, 10,   0,    0, 0,    ST_ALLOCATED},
    '{OP_FREE,  0,    4084, 0, 0,    ST_FREED},
    '{OP_FREE,  0,    4060, 0, 0,    ST_FREED},      // left neighbor free
    '{OP_FREE,  0,    4072, 0, 0,    ST_FREED},      // both neighbors free
    '{OP_ALLOC, 4092, 0,    0, 0,    ST_ALLOCATED},  // the whole heap
    '{OP_ALLOC, 1,    0,    0, 0,    ST_NO_FIT},     // empty free list
    '{OP_FREE,  0,    2,    0, 0,    ST_FREED}
  };

  task automatic send_word(logic op, int unsigned req, int unsigned addr);
    in_word_t w;
    w.operation = op;
    w.request_words = req[11:0];
    w.block_address = addr[11:0];
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_split(logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_split = value;
  endtask

  // One random word: mostly allocates of small sizes and frees of live blocks,
  // with a few huge sizes, double frees and arbitrary addresses as noise.
  task automatic send_random();
    int unsigned pick, idx, req, addr;
    pick = $urandom_range(0, 99);
    if (pick < 50 || live_blocks.size() == 0) begin
      idx = $urandom_range(0, 99);
      if (idx < 70) req = $urandom_range(1, 32);
      else if (idx < 90) req = $urandom_range(33, 400);
      else if (idx < 98) req = $urandom_range(401, 4092);
      else req = $urandom_range(0, 1) ? 0 : $urandom_range(4093, 4095);
      send_word(OP_ALLOC, req, 0);
    end else if (pick < 93) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      addr = live_blocks[idx];
      live_blocks.delete(idx);
      freed_blocks.push_back(addr);
      if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      send_word(OP_FREE, $urandom, addr);
    end else begin
      if (freed_blocks.size() != 0 && $urandom_range(0, 1))
        addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
      else
        addr = $urandom_range(0, 4095);
      send_word(OP_FREE, $urandom, addr);
    end
  endtask

  // Bursts of back-to-back words separated by random gaps.
  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      // Midway through the second phase the receiver holds off for a long
      // stretch while words keep coming, so the allocator backs up.
      if (i == count / 2 && long_hold == 0 && shadow_split == 8'd255) long_hold = 400;
      send_random();
      burst--;
    end
  endtask

  initial begin
    out_word_t want;
    int        sent_before;
    heap_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      sent_before = words_sent;
      send_word(directed_rows[i].op, directed_rows[i].req, directed_rows[i].addr);
      if (directed_rows[i].known) begin
        // Let the predictor record this word at the same edge first.
        wait (words_sent != sent_before);
        // The predictor must agree with the hand-worked result as well.
        want = awaited_results[awaited_results.size() - 1];
        if (want.address != directed_rows[i].want_addr ||
            want.status != directed_rows[i].want_status) begin
          $display("%0t: row %0d expected %0d/%0d actual %0d/%0d", $time, i,
                   directed_rows[i].want_addr, directed_rows[i].want_status,
                   want.address, want.status);
          failures++;
        end
      end
    end
    // The directed rows leave nothing live.
    live_blocks.delete();
    drain_results();

    // Threshold sweep: split whenever possible, give away leftovers up to 255, a random value, reset.
    write_split(8'd0);
    random_phase(PHASE_ITEMS);
    drain_results();
    write_split(8'd255);
    random_phase(PHASE_ITEMS);
    drain_results();
    write_split(8'($urandom_range(1, 254)));
    random_phase(PHASE_ITEMS);
    drain_results();
    write_split(THRESH_RESET);
    random_phase(PHASE_ITEMS);
    in_valid <= 1'b0;

    for (int w = 0; w < IDLE_LIMIT && awaited_results.size() != 0; w++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      failures++;
    end

    $display("Sent %0d words over four split thresholds; %0d results checked.",
             words_sent, results_seen);
    $display("Allocations granted %0d, refused %0d; %0d mismatches.",
             grants, refusals, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
